>>> rtl/core/lbvs_pkg.sv
// Shared types, constants and arithmetic helpers for the vertex skinning core.
package lbvs_pkg;

  localparam int MAT_WORDS = 12;
  localparam int NUM_BONES = 4;

  localparam logic [7:0]  END_ID    = 8'hFF;
  localparam logic [31:0] Q16_ONE   = 32'h0001_0000;
  localparam logic        MODE_WRITE = 1'b0;
  localparam logic        MODE_SKIN  = 1'b1;

  typedef logic signed [31:0] word_t;
  typedef logic [MAT_WORDS-1:0][31:0] mat_t;

  // One palette element write.
  typedef struct packed {
    logic        en;
    logic [5:0]  slot;
    logic [3:0]  word;
    logic [31:0] value;
  } pal_wr_t;

  // Identity matrix element for word index row*4+col.
  function automatic logic [31:0] id_word(input int k);
    return (k == 0 || k == 5 || k == 10) ? Q16_ONE : 32'h0;
  endfunction

  // Clamp a wide signed value into 32-bit signed range.
  function automatic word_t sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -50'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return word_t'(v[31:0]);
  endfunction

  // Round a Q32.32 product to Q16.16, half up.
  function automatic logic signed [49:0] rnd16(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + 64'sd32768) >>> 16;
    return t[49:0];
  endfunction

endpackage

>>> rtl/core/linear_blend_vertex_skinning_core.sv
// A vertex request passes each stage register in turn; palette writes give no result.
// Throughput: one request per cycle, palette writes and vertices alike; the whole pipeline
// stalls only while a result waits at the output register.
// Reset: synchronous; afterwards the palette is loaded with identity matrices, one slot
// per cycle over all PALETTE_SIZE slots (64 by default), while in_ready stays low.
module linear_blend_vertex_skinning_core #(
  parameter int PALETTE_SIZE   = 64,
  parameter int MAX_INFLUENCES = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                mode,
  input  logic [5:0]          palette_slot,
  input  logic [3:0]          palette_word,
  input  logic signed [31:0]  palette_value,
  input  logic [31:0]         bone_ids,
  input  logic [63:0]         bone_weights,
  input  logic signed [31:0]  pos_x,
  input  logic signed [31:0]  pos_y,
  input  logic signed [31:0]  pos_z,
  input  logic signed [31:0]  nrm_x,
  input  logic signed [31:0]  nrm_y,
  input  logic signed [31:0]  nrm_z,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_pos_x,
  output logic signed [31:0]  out_pos_y,
  output logic signed [31:0]  out_pos_z,
  output logic signed [31:0]  out_nrm_x,
  output logic signed [31:0]  out_nrm_y,
  output logic signed [31:0]  out_nrm_z,
  output logic [2:0]          bones_used,
  output logic                status
);
  import lbvs_pkg::*;

  logic    adv, busy, acc_in, skin_in;
  pal_wr_t wr;
  mat_t    rd_data [NUM_BONES];

  // Decode of the incoming bone list.
  logic [3:0][7:0]         ids;
  logic [NUM_BONES-1:0]    use_c;
  logic                    bad_c;
  logic [2:0]              cnt_c;

  // Pipeline registers.
  logic                    v1, v2, v3, v4;
  logic [NUM_BONES-1:0]    use1;
  logic signed [15:0]      w1 [NUM_BONES];
  logic [2:0]              cnt1, cnt2, cnt3, cnt4;
  logic                    bad1, bad2, bad3, bad4;
  word_t                   pos1 [3], pos2 [3], pos3 [3], pos4 [3];
  word_t                   nrm1 [3], nrm2 [3], nrm3 [3], nrm4 [3];
  logic signed [47:0]      prod2 [NUM_BONES][MAT_WORDS];
  word_t                   blend3 [MAT_WORDS];
  logic signed [63:0]      pp4 [3][3];
  logic signed [63:0]      pn4 [3][3];
  word_t                   tr4 [3];

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv && !busy;
  assign acc_in   = in_valid && in_ready;
  assign skin_in  = acc_in && (mode == MODE_SKIN);

  assign wr.en    = acc_in && (mode == MODE_WRITE);
  assign wr.slot  = palette_slot;
  assign wr.word  = palette_word;
  assign wr.value = palette_value;
  assign ids      = bone_ids;

  lbvs_palette #(.PALETTE_SIZE(PALETTE_SIZE)) u_palette (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd_en   (adv),
    .rd_id   (ids),
    .rd_data (rd_data),
    .busy    (busy)
  );

  // The list ends at the first terminator id; listed bones count, in-range
  // bones with a positive weight contribute.
  always_comb begin
    logic term;
    logic lst;
    logic inr;
    term  = 1'b0;
    bad_c = 1'b0;
    cnt_c = '0;
    use_c = '0;
    for (int i = 0; i < NUM_BONES; i++) begin
      lst = (i < MAX_INFLUENCES) && !term && (ids[i] != END_ID);
      if (ids[i] == END_ID) begin
        term = 1'b1;
      end
      inr = ({1'b0, ids[i]} < 9'(PALETTE_SIZE));
      use_c[i] = lst && inr && ($signed(bone_weights[16*i +: 16]) > 16'sd0);
      bad_c = bad_c | (lst && !inr);
      cnt_c = cnt_c + 3'(lst);
    end
  end

  // Valid bits of the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= skin_in;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
  end

  // Stage 1 captures the vertex while the palette is read.
  always_ff @(posedge clk) begin
    if (adv) begin
      use1 <= use_c;
      cnt1 <= cnt_c;
      bad1 <= bad_c;
      for (int i = 0; i < NUM_BONES; i++) begin
        w1[i] <= $signed(bone_weights[16*i +: 16]);
      end
      pos1[0] <= pos_x;
      pos1[1] <= pos_y;
      pos1[2] <= pos_z;
      nrm1[0] <= nrm_x;
      nrm1[1] <= nrm_y;
      nrm1[2] <= nrm_z;
    end
  end

  // Stage 2 weights every element of every contributing bone.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NUM_BONES; i++) begin
        for (int k = 0; k < MAT_WORDS; k++) begin
          prod2[i][k] <= use1[i] ? $signed(rd_data[i][k]) * w1[i] : 48'sd0;
        end
      end
      cnt2 <= cnt1;
      bad2 <= bad1;
      pos2 <= pos1;
      nrm2 <= nrm1;
    end
  end

  // Stage 3 sums the weighted elements and rounds the blend to Q16.16.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < MAT_WORDS; k++) begin
        blend3[k] <= sat32((50'(prod2[0][k]) + 50'(prod2[1][k]) + 50'(prod2[2][k])
                          + 50'(prod2[3][k]) + 50'sd16384) >>> 15);
      end
      cnt3 <= cnt2;
      bad3 <= bad2;
      pos3 <= pos2;
      nrm3 <= nrm2;
    end
  end

  // Stage 4 multiplies the blended 3x3 by the position and the normal.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          pp4[r][c] <= blend3[r*4+c] * pos3[c];
          pn4[r][c] <= blend3[r*4+c] * nrm3[c];
        end
        tr4[r] <= blend3[r*4+3];
      end
      cnt4 <= cnt3;
      bad4 <= bad3;
      pos4 <= pos3;
      nrm4 <= nrm3;
    end
  end

  // Stage 5 rounds, sums and saturates, or copies through when no bone is listed.
  always_ff @(posedge clk) begin
    word_t p_res [3];
    word_t n_res [3];
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        p_res[r] = sat32(rnd16(pp4[r][0]) + rnd16(pp4[r][1]) + rnd16(pp4[r][2])
                         + 50'(tr4[r]));
        n_res[r] = sat32(rnd16(pn4[r][0]) + rnd16(pn4[r][1]) + rnd16(pn4[r][2]));
      end
      out_pos_x  <= (cnt4 == 3'd0) ? pos4[0] : p_res[0];
      out_pos_y  <= (cnt4 == 3'd0) ? pos4[1] : p_res[1];
      out_pos_z  <= (cnt4 == 3'd0) ? pos4[2] : p_res[2];
      out_nrm_x  <= (cnt4 == 3'd0) ? nrm4[0] : n_res[0];
      out_nrm_y  <= (cnt4 == 3'd0) ? nrm4[1] : n_res[1];
      out_nrm_z  <= (cnt4 == 3'd0) ? nrm4[2] : n_res[2];
      bones_used <= cnt4;
      status     <= bad4;
    end
  end

  // A flagged bone is always a listed one.
  a_status_listed: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> bones_used != 3'd0) else $error("status without listed bone");

  // The bone count never exceeds the influence limit.
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> bones_used <= 3'(MAX_INFLUENCES)) else $error("bones_used too large");

  // No request is taken while the palette is being cleared.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_ready) else $error("request accepted during palette clear");

  // An accepted vertex enters the first stage.
  a_skin_enters: assert property (@(posedge clk) disable iff (rst)
    skin_in |=> v1) else $error("vertex request lost");

endmodule

>>> rtl/core/lbvs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module lbvs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/lbvs_palette.sv
// Bone palette: one RAM per matrix element and read port, with a clearing pass after reset.
module lbvs_palette #(
  parameter int PALETTE_SIZE = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  lbvs_pkg::pal_wr_t   wr,
  input  logic                rd_en,
  input  logic [3:0][7:0]     rd_id,
  output lbvs_pkg::mat_t      rd_data [lbvs_pkg::NUM_BONES],
  output logic                busy
);
  import lbvs_pkg::*;

  localparam int AW = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;

  logic [AW-1:0] clr_addr;
  logic [7:0]    slot_ext;
  logic [AW-1:0] wr_addr;
  logic          wr_ok;

  // Only in-range slots and element indexes are stored.
  assign slot_ext = 8'(wr.slot);
  assign wr_addr  = busy ? clr_addr : slot_ext[AW-1:0];
  assign wr_ok    = wr.en && (slot_ext < 8'(PALETTE_SIZE)) && (wr.word < 4'(MAT_WORDS));

  // After reset every slot is loaded with the identity, one slot per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(PALETTE_SIZE - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Each read port has its own copy of every element column.
  for (genvar p = 0; p < NUM_BONES; p++) begin : g_port
    for (genvar k = 0; k < MAT_WORDS; k++) begin : g_word
      logic          we;
      logic [31:0]   wdata;
      logic [AW-1:0] raddr;
      logic [31:0]   rdata;
      assign we    = busy || (wr_ok && (wr.word == 4'(k)));
      assign wdata = busy ? id_word(k) : wr.value;
      assign raddr = rd_id[p][AW-1:0];
      assign rd_data[p][k] = rdata;
      lbvs_ram #(.WIDTH(32), .DEPTH(PALETTE_SIZE)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (wr_addr),
        .wdata (wdata),
        .re    (rd_en),
        .raddr (raddr),
        .rdata (rdata)
      );
    end
  end

endmodule
